[sv/esd_pkg.sv]
// ----------------------------------------------------------------------------
// esd_pkg
// shared types and constants for the euclidean signed divider
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIV_ZERO  = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // per-request side information that rides along the divider stages
  typedef struct packed {
    logic    a_neg;   // dividend negative
    logic    q_neg;   // quotient negative
    status_t status;
  } esd_ctrl_t;

endpackage

`default_nettype wire

[sv/esd_prep.sv]
// ----------------------------------------------------------------------------
// esd_prep
// operand magnitudes, sign bookkeeping and special case detection
// ----------------------------------------------------------------------------
`default_nettype none

module esd_prep import esd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [DATA_WIDTH-1:0] rem,
  output      logic [DATA_WIDTH-1:0] quo,
  output      logic [DATA_WIDTH-1:0] ub,
  output      esd_ctrl_t             ctrl
);

  localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic      a_neg;
  logic      b_neg;
  esd_ctrl_t ctrl_next;

  assign a_neg    = dividend[DATA_WIDTH-1];
  assign b_neg    = divisor[DATA_WIDTH-1];
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    ctrl_next.a_neg = a_neg;
    ctrl_next.q_neg = a_neg ^ b_neg;
    if (divisor == '0) begin
      ctrl_next.status = ST_DIV_ZERO;
    end else if (dividend == SIGN_BIT && divisor == '1) begin
      ctrl_next.status = ST_OVERFLOW;
    end else begin
      ctrl_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem  <= '0;
      quo  <= a_neg ? (~dividend + 1'b1) : dividend;
      ub   <= b_neg ? (~divisor + 1'b1) : divisor;
      ctrl <= ctrl_next;
    end
  end

endmodule

`default_nettype wire

[sv/esd_step.sv]
// ----------------------------------------------------------------------------
// esd_step
// one restoring division step, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module esd_step import esd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [DATA_WIDTH-1:0] rem_in,
  input  wire logic [DATA_WIDTH-1:0] quo_in,
  input  wire logic [DATA_WIDTH-1:0] ub_in,
  input  wire esd_ctrl_t             ctrl_in,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [DATA_WIDTH-1:0] rem,
  output      logic [DATA_WIDTH-1:0] quo,
  output      logic [DATA_WIDTH-1:0] ub,
  output      esd_ctrl_t             ctrl
);

  logic [DATA_WIDTH:0] shifted;
  logic [DATA_WIDTH:0] diff;
  logic                fits;

  // bring down the next dividend bit and try a subtract
  assign shifted  = {rem_in, quo_in[DATA_WIDTH-1]};
  assign diff     = shifted - {1'b0, ub_in};
  assign fits     = !diff[DATA_WIDTH];
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem  <= fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo  <= {quo_in[DATA_WIDTH-2:0], fits};
      ub   <= ub_in;
      ctrl <= ctrl_in;
    end
  end

endmodule

`default_nettype wire

[sv/esd_fix.sv]
// ----------------------------------------------------------------------------
// esd_fix
// euclidean correction, sign restore and result register
// ----------------------------------------------------------------------------
`default_nettype none

module esd_fix import esd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [DATA_WIDTH-1:0] rem_in,
  input  wire logic [DATA_WIDTH-1:0] quo_in,
  input  wire logic [DATA_WIDTH-1:0] ub_in,
  input  wire esd_ctrl_t             ctrl_in,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [DATA_WIDTH-1:0] quotient,
  output      logic [DATA_WIDTH-2:0] remainder,
  output      status_t               status
);

  logic                  bump;
  logic [DATA_WIDTH-1:0] qm;
  logic [DATA_WIDTH-1:0] rm;
  logic [DATA_WIDTH-1:0] q_next;

  // negative inexact dividend: one more step away from zero
  assign bump     = ctrl_in.a_neg && (rem_in != '0);
  assign qm       = bump ? (quo_in + 1'b1) : quo_in;
  assign rm       = bump ? (ub_in - rem_in) : rem_in;
  assign q_next   = ctrl_in.q_neg ? (~qm + 1'b1) : qm;
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      status <= ctrl_in.status;
      if (ctrl_in.status == ST_OK) begin
        quotient  <= q_next;
        remainder <= rm[DATA_WIDTH-2:0];
      end else begin
        quotient  <= '0;
        remainder <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/euclidean_signed_divider.sv]
// ----------------------------------------------------------------------------
// euclidean_signed_divider
// pipelined signed divider with euclidean quotient and remainder
// ----------------------------------------------------------------------------
// stages from request accept to result valid, each one registered, in order:
// one prep stage, one restoring step per quotient bit, one correction stage
// throughput: one request per cycle; each stage stalls only when full and the
// stage after it cannot take its contents, so bubbles are squeezed out
// reset: synchronous active-high rst clears every stage valid bit
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_signed_divider import esd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int IN_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((2 * DATA_WIDTH - 1 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // request side
  input  wire logic             s_axis_tvalid,
  output      logic             s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,   // dividend, divisor, zero pad
  // result side
  output      logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output      logic [OUT_W-1:0] m_axis_tdata,   // quotient, remainder, zero pad
  output      logic [1:0]       m_axis_tuser    // status
);

  localparam int STEPS = DATA_WIDTH;

  // stage buses: index 0 is the prep output, index STEPS the last step output
  logic                  valid_pipe [0:STEPS];
  logic                  ready_pipe [0:STEPS];
  logic [DATA_WIDTH-1:0] rem_pipe   [0:STEPS];
  logic [DATA_WIDTH-1:0] quo_pipe   [0:STEPS];
  logic [DATA_WIDTH-1:0] ub_pipe    [0:STEPS];
  esd_ctrl_t             ctrl_pipe  [0:STEPS];

  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH-2:0] remainder;
  status_t               status;

  // operand unpacking and sign handling
  esd_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .dividend  (s_axis_tdata[DATA_WIDTH-1:0]),
    .divisor   (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .out_valid (valid_pipe[0]),
    .out_ready (ready_pipe[0]),
    .rem       (rem_pipe[0]),
    .quo       (quo_pipe[0]),
    .ub        (ub_pipe[0]),
    .ctrl      (ctrl_pipe[0])
  );

  // one magnitude quotient bit per stage, msb first
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    esd_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_pipe[i]),
      .in_ready  (ready_pipe[i]),
      .rem_in    (rem_pipe[i]),
      .quo_in    (quo_pipe[i]),
      .ub_in     (ub_pipe[i]),
      .ctrl_in   (ctrl_pipe[i]),
      .out_valid (valid_pipe[i+1]),
      .out_ready (ready_pipe[i+1]),
      .rem       (rem_pipe[i+1]),
      .quo       (quo_pipe[i+1]),
      .ub        (ub_pipe[i+1]),
      .ctrl      (ctrl_pipe[i+1])
    );
  end

  // euclidean fixup and the result register that faces the consumer
  esd_fix #(.DATA_WIDTH(DATA_WIDTH)) u_fix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_pipe[STEPS]),
    .in_ready  (ready_pipe[STEPS]),
    .rem_in    (rem_pipe[STEPS]),
    .quo_in    (quo_pipe[STEPS]),
    .ub_in     (ub_pipe[STEPS]),
    .ctrl_in   (ctrl_pipe[STEPS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .quotient  (quotient),
    .remainder (remainder),
    .status    (status)
  );

  // result packing, padding bits held at zero
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[2*DATA_WIDTH-2:0] = {remainder, quotient};
  end

  assign m_axis_tuser = status;

  // flagged results carry zero payload
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("flagged result with nonzero payload");

  // the pipe only pushes back on requests when the result register is full
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("request refused while result register empty");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the euclidean signed divider
// ----------------------------------------------------------------------------
// every request sent is run through a behavioral euclidean division model and
// the expected quotient, remainder and status are queued in order; each result
// taken from the master side is compared against the oldest queued entry.
// tests: directed corners (zero divisor, overflow, sign mixes, extreme values),
// a random mix weighted toward the interesting cases, and a back-pressure run
// where the result side holds off long enough to fill the pipeline
// ----------------------------------------------------------------------------

module tb_top;
  import esd_pkg::*;

  localparam int DW          = 32;
  localparam int IN_W        = ((2 * DW + 7) / 8) * 8;
  localparam int OUT_W       = ((2 * DW - 1 + 7) / 8) * 8;
  localparam int LATENCY     = DW + 2;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};

  // one expected result, with its operands kept for messages
  typedef struct {
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
    logic [DW-1:0] quotient;
    logic [DW-2:0] remainder;
    status_t       status;
  } division_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;

  division_t expected_divisions[$];

  bit gaps_on          = 1'b1;  // random idling on both sides
  bit hold_off_pending = 1'b0;  // asks the result side for one long hold-off
  int mismatches       = 0;
  int requests_sent    = 0;
  int results_checked  = 0;
  int input_stalls     = 0;
  int status_seen[3]   = '{0, 0, 0};

  euclidean_signed_divider #(
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),    // dividend, divisor, zero pad
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),    // quotient, remainder, zero pad
    .m_axis_tuser  (m_tuser)     // status
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // euclidean division on the block's widths: remainder never negative
  function automatic division_t predict_division(input logic [DW-1:0] dvd,
                                                 input logic [DW-1:0] dsr);
    division_t     res;
    logic [DW-1:0] mag_dvd;
    logic [DW-1:0] mag_dsr;
    logic [DW-1:0] qmag;
    logic [DW-1:0] rmag;
    res.dividend  = dvd;
    res.divisor   = dsr;
    res.quotient  = '0;
    res.remainder = '0;
    res.status    = ST_OK;
    if (dsr == '0) begin
      res.status = ST_DIV_ZERO;
    end else if (dvd == MIN_VAL && dsr == '1) begin
      res.status = ST_OVERFLOW;
    end else begin
      mag_dvd = dvd[DW-1] ? -dvd : dvd;
      mag_dsr = dsr[DW-1] ? -dsr : dsr;
      qmag    = mag_dvd / mag_dsr;
      rmag    = mag_dvd % mag_dsr;
      // negative dividend with a leftover: step the magnitude up so the
      // remainder comes out positive
      if (dvd[DW-1] && rmag != '0) begin
        qmag = qmag + 1'b1;
        rmag = mag_dsr - rmag;
      end
      res.quotient  = (dvd[DW-1] ^ dsr[DW-1]) ? -qmag : qmag;
      res.remainder = rmag[DW-2:0];
    end
    return res;
  endfunction

  // drives one request, called and returning at a falling edge
  task automatic send_division(input logic [DW-1:0] dvd, input logic [DW-1:0] dsr);
    while (gaps_on && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({dsr, dvd});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_divisions.push_back(predict_division(dvd, dsr));
    requests_sent++;
    @(negedge clk);
  endtask

  // result side readiness: random gaps, plus one long hold-off on request
  always begin
    @(negedge clk);
    if (hold_off_pending) begin
      hold_off_pending = 1'b0;
      m_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
    end
    m_tready <= !(gaps_on && $urandom_range(0, 99) < 7);
  end

  // result checker
  always @(posedge clk) begin
    division_t exp_res;
    if (!rst) begin
      if (s_tvalid && !s_tready) input_stalls++;
      if (m_tvalid && m_tready) begin
        if (expected_divisions.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: q=%0d r=%0d status=%0d",
                     $signed(m_tdata[DW-1:0]), m_tdata[2*DW-2:DW], m_tuser);
        end else begin
          exp_res = expected_divisions.pop_front();
          results_checked++;
          if (exp_res.status inside {ST_OK, ST_DIV_ZERO, ST_OVERFLOW})
            status_seen[exp_res.status]++;
          if (m_tdata[DW-1:0] !== exp_res.quotient ||
              m_tdata[2*DW-2:DW] !== exp_res.remainder ||
              m_tuser !== exp_res.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch %0d / %0d: expected q=%0d r=%0d status=%0d,",
                        " got q=%0d r=%0d status=%0d"},
                       $signed(exp_res.dividend), $signed(exp_res.divisor),
                       $signed(exp_res.quotient), exp_res.remainder, exp_res.status,
                       $signed(m_tdata[DW-1:0]), m_tdata[2*DW-2:DW], m_tuser);
          end
        end
      end
    end
  end

  // corners: zero divisor, overflow, every sign mix, exact and inexact,
  // extreme magnitudes on both operands
  task automatic test_directed_corners();
    send_division(32'sd7, 32'sd2);
    send_division(-32'sd7, 32'sd2);
    send_division(32'sd7, -32'sd2);
    send_division(-32'sd7, -32'sd2);
    send_division(-32'sd8, 32'sd2);
    send_division(-32'sd8, -32'sd2);
    send_division(32'sd0, -32'sd5);
    send_division(-32'sd1, -32'sd1);
    send_division(32'sd5, 32'sd0);
    send_division(32'sd0, 32'sd0);
    send_division(MIN_VAL, 32'sd0);
    send_division(MIN_VAL, -32'sd1);
    send_division(MIN_VAL, 32'sd1);
    send_division(MIN_VAL, 32'sd2);
    send_division(MIN_VAL, -32'sd2);
    send_division(MIN_VAL, MAX_VAL);
    send_division(MIN_VAL, MIN_VAL);
    send_division(MAX_VAL, 32'sd1);
    send_division(MAX_VAL, -32'sd1);
    send_division(MAX_VAL, MIN_VAL);
    send_division(MAX_VAL, MAX_VAL);
    send_division(-32'sd1, MIN_VAL);
    send_division(32'sd1, MIN_VAL);
    send_division(-32'sd1, MAX_VAL);
    send_division(32'hFFFF_FFFF, 32'h7FFF_FFFE);
  endtask

  // random operands, weighted toward small values, unit and zero divisors,
  // the most negative dividend, exact multiples and extreme divisors
  task automatic test_random_mix(input int count);
    logic [DW-1:0] dvd;
    logic [DW-1:0] dsr;
    int            pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      dvd  = $urandom();
      dsr  = $urandom();
      if (pick < 45) begin
        // full range on both
      end else if (pick < 65) begin
        dvd = DW'($urandom_range(0, 40) - 20);
        dsr = DW'($urandom_range(0, 16) - 8);
      end else if (pick < 73) begin
        dsr = $urandom_range(0, 1) ? DW'(1) : '1;
      end else if (pick < 78) begin
        dsr = '0;
      end else if (pick < 86) begin
        dvd = MIN_VAL;
        if ($urandom_range(0, 2) == 0) dsr = '1;
      end else if (pick < 94) begin
        dsr = DW'($urandom_range(1, 1000));
        if ($urandom_range(0, 1)) dsr = -dsr;
        dvd = dsr * DW'($urandom_range(0, 4000) - 2000);
      end else begin
        dsr = $urandom_range(0, 1) ? MIN_VAL : MAX_VAL;
      end
      send_division(dvd, dsr);
    end
  endtask

  // result side stops for a long stretch while requests keep coming, so the
  // pipeline fills and the request side must stall
  task automatic test_backpressure(input int count);
    hold_off_pending = 1'b1;
    for (int n = 0; n < count; n++)
      send_division($urandom(), $urandom_range(0, 3) == 0 ? DW'($urandom_range(0, 9)) :
                    DW'($urandom()));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_corners();
    gaps_on = 1'b0;
    test_random_mix(150);
    gaps_on = 1'b1;
    test_random_mix(250);
    test_backpressure(80);
    s_tvalid <= 1'b0;

    while (expected_divisions.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("ran %0d divisions, %0d results checked", requests_sent, results_checked);
    $display("ok %0d, zero divisor %0d, overflow %0d; input stalled %0d cycles, %0d mismatches",
             status_seen[ST_OK], status_seen[ST_DIV_ZERO], status_seen[ST_OVERFLOW],
             input_stalls, mismatches);
    if (mismatches == 0 && expected_divisions.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
sv/esd_pkg.sv
sv/esd_prep.sv
sv/esd_step.sv
sv/esd_fix.sv
sv/euclidean_signed_divider.sv
tb/tb_top.sv
